[src/sgf_pkg.sv]
package sgf_pkg;

  // Default formats
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ANGLE_BITS_DEF = 16;

  // Term cap and most negative radial rate
  localparam logic [63:0] TERM_CAP  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  // Sine polynomial in Q30, odd Taylor terms of sin(pi/2 u), highest power first
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam int          SIN_TAPS = 5;
  localparam logic [30:0] SIN_COEF [SIN_TAPS] = '{
    31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
  };
  localparam int SIN_LAT = 7;

  // M v^2 / d^2 unit: four set-up stages, then one stage per quotient bit
  localparam int QBITS  = 63;
  localparam int MT_PRE = 4;
  localparam int MT_LAT = MT_PRE + QBITS;

  typedef struct packed {
    logic        [31:0] radius;
    logic        [15:0] polar_angle;
    logic signed [31:0] vel_time;
    logic signed [31:0] vel_radial;
    logic signed [31:0] vel_polar;
    logic signed [31:0] vel_azimuth;
  } point_t;

  typedef struct packed {
    logic signed [63:0] rate_radial;
    logic signed [63:0] rate_polar;
    logic               bad_radius;
    logic               saturated;
  } rate_t;

  typedef logic [31:0] mass_t;

  // Magnitude of a two's complement velocity word
  function automatic logic [31:0] vel_mag(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  // Scale by 2^-rs and cap at TERM_CAP; bit 64 of the result flags the cap
  function automatic logic [64:0] cap_scale(input logic [159:0] x, input int rs);
    logic [159:0] y;
    logic         over;
    over = (x >> (63 + rs)) != '0;
    if (rs >= 0) begin
      y = x >> rs;
    end else begin
      y = x << (-rs);
    end
    return over ? {1'b1, TERM_CAP} : {1'b0, y[63:0]};
  endfunction

endpackage

[src/sgf_stream_if.sv]
interface sgf_stream_if #(parameter type data_t = logic);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/sgf_delay.sv]
module sgf_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] d,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] taps [DEPTH];

  // Shift line, moves with the pipeline
  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
    end
  end

  for (genvar k = 1; k < DEPTH; k++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) begin
        taps[k] <= taps[k-1];
      end
    end
  end

  assign q = taps[DEPTH-1];

endmodule

[src/sgf_sine.sv]
module sgf_sine (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] phase,
  output logic [30:0] mag,
  output logic        neg
);

  localparam logic [30:0] ONE_Q30_L = sgf_pkg::ONE_Q30;

  // Stage a: fold into first quadrant, square
  logic [30:0] u_a;
  logic [1:0]  q_a;
  logic [61:0] pr_a;
  logic [30:0] u_fold;

  assign u_fold = phase[30] ? (ONE_Q30_L - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};

  always_ff @(posedge clk) begin
    if (en) begin
      u_a  <= u_fold;
      q_a  <= phase[31:30];
      pr_a <= 62'(u_fold) * 62'(u_fold);
    end
  end

  // Horner stages: index 0 multiplies u^2 by the top coefficient
  logic [30:0] u_s  [sgf_pkg::SIN_TAPS];
  logic [30:0] u2_s [sgf_pkg::SIN_TAPS];
  logic [1:0]  q_s  [sgf_pkg::SIN_TAPS];
  logic [61:0] pr_s [sgf_pkg::SIN_TAPS];
  logic [30:0] u2_a;

  assign u2_a = 31'(pr_a >> 30);

  always_ff @(posedge clk) begin
    if (en) begin
      u_s[0]  <= u_a;
      u2_s[0] <= u2_a;
      q_s[0]  <= q_a;
      pr_s[0] <= 62'(u2_a) * 62'(sgf_pkg::SIN_COEF[0]);
    end
  end

  for (genvar k = 1; k < sgf_pkg::SIN_TAPS; k++) begin : g_horner
    logic [31:0] acc;
    logic [30:0] src;
    assign acc = 32'(sgf_pkg::SIN_COEF[k]) - 32'(pr_s[k-1] >> 30);
    // last step multiplies by u, the others by u^2
    assign src = (k == sgf_pkg::SIN_TAPS - 1) ? u_s[k-1] : u2_s[k-1];
    always_ff @(posedge clk) begin
      if (en) begin
        u_s[k]  <= u_s[k-1];
        u2_s[k] <= u2_s[k-1];
        q_s[k]  <= q_s[k-1];
        pr_s[k] <= 62'(src) * 62'(acc[30:0]);
      end
    end
  end

  // Output stage: clamp to 1.0, lower half-turn is negative
  logic [31:0] m_raw;
  logic [30:0] m_clip;

  assign m_raw  = 32'(pr_s[sgf_pkg::SIN_TAPS-1] >> 30);
  assign m_clip = (m_raw > 32'(ONE_Q30_L)) ? ONE_Q30_L : m_raw[30:0];

  always_ff @(posedge clk) begin
    if (en) begin
      mag <= m_clip;
      neg <= q_s[sgf_pkg::SIN_TAPS-1][1] && (m_clip != '0);
    end
  end

endmodule

[src/sgf_mass_term.sv]
module sgf_mass_term #(
  parameter int FRAC_BITS = sgf_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] mass,
  input  logic [31:0] vmag,
  input  logic [32:0] den,
  output logic [63:0] term,
  output logic        sat
);

  // floor(M v^2 2^(32-F) / den^2), capped; divider is one stage per quotient bit

  localparam int QB = sgf_pkg::QBITS;

  // Set-up 1: squares
  logic [63:0] vsq_1;
  logic [65:0] dd_1;
  logic [31:0] mass_1;

  always_ff @(posedge clk) begin
    if (en) begin
      vsq_1  <= 64'(vmag) * 64'(vmag);
      dd_1   <= 66'(den) * 66'(den);
      mass_1 <= mass;
    end
  end

  // Set-up 2: partial products of M * v^2
  logic [63:0] pl_2;
  logic [63:0] ph_2;
  logic [65:0] dd_2;

  always_ff @(posedge clk) begin
    if (en) begin
      pl_2 <= 64'(mass_1) * 64'(vsq_1[31:0]);
      ph_2 <= 64'(mass_1) * 64'(vsq_1[63:32]);
      dd_2 <= dd_1;
    end
  end

  // Set-up 3: sum of partials
  logic [95:0] num_3;
  logic [65:0] dd_3;

  always_ff @(posedge clk) begin
    if (en) begin
      num_3 <= 96'(pl_2) + {ph_2, 32'h0};
      dd_3  <= dd_2;
    end
  end

  // Set-up 4: overflow test, quotient >= 2^63 caps
  logic [127:0] nfull;
  logic [64:0]  nhi;

  assign nfull = {32'h0, num_3} << (32 - FRAC_BITS);
  assign nhi   = nfull[127:63];

  logic [65:0]      rem [QB+1];
  logic [QB-1:0]    nq  [QB+1];
  logic [65:0]      dd  [QB+1];
  logic             ov  [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= 66'(nhi);
      nq[0]  <= nfull[QB-1:0];
      dd[0]  <= dd_3;
      ov[0]  <= 66'(nhi) >= dd_3;
    end
  end

  // Restoring steps: numerator bits shift out, quotient bits shift in
  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [66:0] trial;
    logic        ge;
    assign trial = {rem[k-1], nq[k-1][QB-1]};
    assign ge    = trial >= {1'b0, dd[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? 66'(trial - {1'b0, dd[k-1]}) : trial[65:0];
        nq[k]  <= {nq[k-1][QB-2:0], ge};
        dd[k]  <= dd[k-1];
        ov[k]  <= ov[k-1];
      end
    end
  end

  assign term = ov[QB] ? sgf_pkg::TERM_CAP : {1'b0, nq[QB]};
  assign sat  = ov[QB];

endmodule

[src/schwarzschild_geodesic_force_core.sv]
// Streaming Schwarzschild force unit. Each point word (r, theta, four velocity
// components) yields one rate word, radial and polar covariant momentum rates
// in saturating Q31.32, with a flag for r = 0 or r = 2M and a flag for any
// clipping. Unless stalled, the pipeline takes a new point every cycle and
// has 70 register stages from point to result; the depth is set by
// the two 63-stage restoring dividers that form M v^2 / r^2 and
// M v^2 / (r-2M)^2. A stall on the result side holds the whole pipeline and
// drops point ready; the result register keeps its word until taken. The mass
// register (reset 1.0) is written through the cfg channel, which is always
// ready; write it only while no point is in flight.
module schwarzschild_geodesic_force_core #(
  parameter int FRAC_BITS  = sgf_pkg::FRAC_BITS_DEF,
  parameter int ANGLE_BITS = sgf_pkg::ANGLE_BITS_DEF
) (
  input logic          clk,
  input logic          rst,
  sgf_stream_if.sink   point,
  sgf_stream_if.source rate,
  sgf_stream_if.sink   cfg
);

  localparam int STG_SIN  = 1 + sgf_pkg::SIN_LAT;
  localparam int STG_TERM = 1 + sgf_pkg::MT_LAT;
  localparam int LAT      = STG_TERM + 2;
  localparam int D_T3     = STG_TERM - 5;
  localparam int D_T4     = STG_TERM - (STG_SIN + 4);
  localparam int D_PL     = STG_TERM - (STG_SIN + 3);
  localparam int D_R      = STG_SIN + 1 - 4;
  localparam int D_P      = STG_SIN - 4;
  localparam int D_BAD    = STG_TERM - 1;

  logic           en;
  logic [LAT-1:0] vld;
  logic [31:0]    mass;

  // Pipeline advances unless the result register is full and stalled
  assign en          = !vld[LAT-1] || rate.ready;
  assign point.ready = en;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], point.valid};
    end
  end

  // Mass register
  always_ff @(posedge clk) begin
    if (rst) begin
      mass <= 32'(1) << FRAC_BITS;
    end else if (cfg.valid && cfg.ready) begin
      mass <= cfg.data;
    end
  end

  // Stage 1: magnitudes, phase, distance to 2M
  logic [32:0] twice_m;
  logic [32:0] rad33;
  logic [31:0] ang_m;
  logic [31:0] phase_in;

  assign twice_m  = {mass, 1'b0};
  assign rad33    = {1'b0, point.data.radius};
  assign ang_m    = {16'h0, point.data.polar_angle} & ((32'd1 << ANGLE_BITS) - 32'd1);
  assign phase_in = ang_m << (32 - ANGLE_BITS);

  logic [31:0] p_rad, p_phase, p_mass;
  logic [31:0] p_mt, p_mr, p_mth, p_mph;
  logic [32:0] p_gap;
  logic        p_bad;

  always_ff @(posedge clk) begin
    if (en) begin
      p_rad   <= point.data.radius;
      p_phase <= phase_in;
      p_mass  <= mass;
      p_mt    <= sgf_pkg::vel_mag(point.data.vel_time);
      p_mr    <= sgf_pkg::vel_mag(point.data.vel_radial);
      p_mth   <= sgf_pkg::vel_mag(point.data.vel_polar);
      p_mph   <= sgf_pkg::vel_mag(point.data.vel_azimuth);
      p_gap   <= (rad33 > twice_m) ? (rad33 - twice_m) : (twice_m - rad33);
      p_bad   <= (point.data.radius == '0) || (rad33 == twice_m);
    end
  end

  // Mass terms: M vt^2 / r^2 and M vr^2 / (r-2M)^2
  logic [63:0] t1, t2;
  logic        sat1, sat2;

  sgf_mass_term #(.FRAC_BITS(FRAC_BITS)) u_term_t (
    .clk(clk), .en(en), .mass(p_mass), .vmag(p_mt), .den({1'b0, p_rad}),
    .term(t1), .sat(sat1)
  );

  sgf_mass_term #(.FRAC_BITS(FRAC_BITS)) u_term_r (
    .clk(clk), .en(en), .mass(p_mass), .vmag(p_mr), .den(p_gap),
    .term(t2), .sat(sat2)
  );

  // Sines of theta and 2 theta
  logic [30:0] sn_mag, sc_mag;
  logic        sc_neg;

  sgf_sine u_sin_1 (
    .clk(clk), .en(en), .phase(p_phase), .mag(sn_mag), .neg()
  );

  sgf_sine u_sin_2 (
    .clk(clk), .en(en), .phase({p_phase[30:0], 1'b0}), .mag(sc_mag), .neg(sc_neg)
  );

  // Stage 2: velocity squares and r^2
  logic [31:0] s2_rad;
  logic [63:0] s2_sqth, s2_sqph, s2_rr;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_rad  <= p_rad;
      s2_sqth <= 64'(p_mth) * 64'(p_mth);
      s2_sqph <= 64'(p_mph) * 64'(p_mph);
      s2_rr   <= 64'(p_rad) * 64'(p_rad);
    end
  end

  // Stage 3: partial products
  logic [63:0] s3_a_lo, s3_a_hi, s3_b_lo, s3_b_hi;
  logic [63:0] s3_p00, s3_p01, s3_p10, s3_p11;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_a_lo <= 64'(s2_rad) * 64'(s2_sqth[31:0]);
      s3_a_hi <= 64'(s2_rad) * 64'(s2_sqth[63:32]);
      s3_b_lo <= 64'(s2_rad) * 64'(s2_sqph[31:0]);
      s3_b_hi <= 64'(s2_rad) * 64'(s2_sqph[63:32]);
      s3_p00  <= 64'(s2_rr[31:0])  * 64'(s2_sqph[31:0]);
      s3_p01  <= 64'(s2_rr[31:0])  * 64'(s2_sqph[63:32]);
      s3_p10  <= 64'(s2_rr[63:32]) * 64'(s2_sqph[31:0]);
      s3_p11  <= 64'(s2_rr[63:32]) * 64'(s2_sqph[63:32]);
    end
  end

  // Stage 4: r vth^2, r vph^2, r^2 vph^2
  logic [95:0]  s4_x3, s4_r;
  logic [127:0] s4_p;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_x3 <= 96'(s3_a_lo) + {s3_a_hi, 32'h0};
      s4_r  <= 96'(s3_b_lo) + {s3_b_hi, 32'h0};
      s4_p  <= 128'(s3_p00) + 128'({s3_p01, 32'h0}) + 128'({s3_p10, 32'h0})
             + {s3_p11, 64'h0};
    end
  end

  // Stage 5: third radial term
  logic [64:0] s5_t3;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_t3 <= sgf_pkg::cap_scale(160'(s4_x3), 3 * FRAC_BITS - 32);
    end
  end

  // Align products with the sine outputs
  logic [95:0]  r_d;
  logic [127:0] p_d;

  sgf_delay #(.WIDTH(96), .DEPTH(D_R)) u_dly_r (
    .clk(clk), .en(en), .d(s4_r), .q(r_d)
  );

  sgf_delay #(.WIDTH(128), .DEPTH(D_P)) u_dly_p (
    .clk(clk), .en(en), .d(s4_p), .q(p_d)
  );

  // Polar path: r^2 vph^2 times sin(2 theta)
  logic [63:0]  s9_e [4];
  logic         s9_neg;
  logic [30:0]  s9_s2;
  logic [159:0] s10_x5;
  logic         s10_neg;
  logic [64:0]  pl_cap;
  logic [64:0]  s11_pl;

  always_ff @(posedge clk) begin
    if (en) begin
      s9_e[0] <= 64'(p_d[31:0])   * 64'(sc_mag);
      s9_e[1] <= 64'(p_d[63:32])  * 64'(sc_mag);
      s9_e[2] <= 64'(p_d[95:64])  * 64'(sc_mag);
      s9_e[3] <= 64'(p_d[127:96]) * 64'(sc_mag);
      s9_neg  <= sc_neg;
      s9_s2   <= 31'((62'(sn_mag) * 62'(sn_mag)) >> 30);
      s10_x5  <= 160'(s9_e[0]) + 160'({s9_e[1], 32'h0}) + 160'({s9_e[2], 64'h0})
               + 160'({s9_e[3], 96'h0});
      s10_neg <= s9_neg;
    end
  end

  assign pl_cap = sgf_pkg::cap_scale(s10_x5, 4 * FRAC_BITS - 1);

  always_ff @(posedge clk) begin
    if (en) begin
      s11_pl <= {pl_cap[64], s10_neg ? (64'h0 - pl_cap[63:0]) : pl_cap[63:0]};
    end
  end

  // Fourth radial term: r vph^2 sin^2(theta)
  logic [63:0]  s10_c [3];
  logic [127:0] s11_x4;
  logic [64:0]  s12_t4;

  always_ff @(posedge clk) begin
    if (en) begin
      s10_c[0] <= 64'(r_d[31:0])  * 64'(s9_s2);
      s10_c[1] <= 64'(r_d[63:32]) * 64'(s9_s2);
      s10_c[2] <= 64'(r_d[95:64]) * 64'(s9_s2);
      s11_x4   <= 128'(s10_c[0]) + 128'({s10_c[1], 32'h0}) + 128'({s10_c[2], 64'h0});
      s12_t4   <= sgf_pkg::cap_scale(160'(s11_x4), 3 * FRAC_BITS - 2);
    end
  end

  // Bring everything to the divider outputs
  logic [64:0] t3_d, t4_d, pl_d;
  logic        bad_d;

  sgf_delay #(.WIDTH(65), .DEPTH(D_T3)) u_dly_t3 (
    .clk(clk), .en(en), .d(s5_t3), .q(t3_d)
  );

  sgf_delay #(.WIDTH(65), .DEPTH(D_T4)) u_dly_t4 (
    .clk(clk), .en(en), .d(s12_t4), .q(t4_d)
  );

  sgf_delay #(.WIDTH(65), .DEPTH(D_PL)) u_dly_pl (
    .clk(clk), .en(en), .d(s11_pl), .q(pl_d)
  );

  sgf_delay #(.WIDTH(1), .DEPTH(D_BAD)) u_dly_bad (
    .clk(clk), .en(en), .d(p_bad), .q(bad_d)
  );

  // Positive and negative sums
  logic [63:0] f_pos, f_neg, f_polar;
  logic        f_satr, f_satp, f_bad;

  always_ff @(posedge clk) begin
    if (en) begin
      f_pos   <= t3_d[63:0] + t4_d[63:0];
      f_neg   <= t1 + t2;
      f_satr  <= sat1 | sat2 | t3_d[64] | t4_d[64];
      f_satp  <= pl_d[64];
      f_polar <= pl_d[63:0];
      f_bad   <= bad_d;
    end
  end

  // Difference with clamp to the signed range
  logic        ge;
  logic [63:0] dpos, dneg;
  logic        capf;
  logic [63:0] radial;

  assign ge   = f_pos >= f_neg;
  assign dpos = f_pos - f_neg;
  assign dneg = f_neg - f_pos;

  always_comb begin
    capf   = 1'b0;
    radial = '0;
    if (!f_bad) begin
      if (ge) begin
        capf   = dpos > sgf_pkg::TERM_CAP;
        radial = capf ? sgf_pkg::TERM_CAP : dpos;
      end else begin
        capf   = dneg > sgf_pkg::NEG_LIMIT;
        radial = 64'h0 - (capf ? sgf_pkg::NEG_LIMIT : dneg);
      end
    end
  end

  // Result register
  sgf_pkg::rate_t out_q;

  always_ff @(posedge clk) begin
    if (en) begin
      out_q.rate_radial <= radial;
      out_q.rate_polar  <= f_polar;
      out_q.bad_radius  <= f_bad;
      out_q.saturated   <= f_satp | (!f_bad & (f_satr | capf));
    end
  end

  assign rate.valid = vld[LAT-1];
  assign rate.data  = out_q;

endmodule

[src/sgf_checker.sv]
module sgf_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input sgf_pkg::rate_t out_data
);

  // Result word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result word changed while stalled");

  // Bad radius gives a zero radial rate
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.bad_radius |-> out_data.rate_radial == '0)
    else $error("radial rate not zero on bad radius");

  // Empty result register never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind schwarzschild_geodesic_force_core sgf_checker u_sgf_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(point.ready),
  .out_valid(rate.valid),
  .out_ready(rate.ready),
  .out_data(rate.data)
);
